### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rasterizer rtl
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define VSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// trigger at one edge implies the condition at the next edge
`define VSR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) trig |=> cond) else $error(msg);

`endif

### sv/vsr_pkg.sv
// ----------------------------------------------------------------------------
// vsr_pkg
// grid sizes, field widths, operation codes and the controller/datapath types
// ----------------------------------------------------------------------------
`default_nettype none

package vsr_pkg;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;
  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int IX_W   = $clog2(GRID_X);
  localparam int IY_W   = $clog2(GRID_Y);
  localparam int IZ_W   = $clog2(GRID_Z);

  // signed working width for coordinates and differences
  localparam int CRD_W  = 10;
  // squared difference, |d| <= 16 once the centre is in range
  localparam int SQ_W   = 13;
  // squared 8-bit semi-axis or radius
  localparam int AX_W   = 15;
  localparam int RR_W   = 15;
  localparam int S_W    = 15;
  localparam int PAIR_W = 29;
  localparam int TRI_W  = 43;
  localparam int PROD_W = SQ_W + PAIR_W;
  localparam int ESUM_W = PROD_W + 2;

  localparam int FLD_W  = 8;
  localparam int COL_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [CRD_W-1:0] GX_S = CRD_W'(GRID_X);
  localparam logic signed [CRD_W-1:0] GY_S = CRD_W'(GRID_Y);
  localparam logic signed [CRD_W-1:0] GZ_S = CRD_W'(GRID_Z);

  typedef enum logic [3:0] {
    OP_SET_VOXEL   = 4'd0,
    OP_CLR_VOXEL   = 4'd1,
    OP_SET_BOX     = 4'd2,
    OP_CLR_BOX     = 4'd3,
    OP_SET_SPHERE  = 4'd4,
    OP_CLR_SPHERE  = 4'd5,
    OP_SET_ELLIPS  = 4'd6,
    OP_CLR_ELLIPS  = 4'd7,
    OP_SET_CYL     = 4'd8,
    OP_SET_DISC    = 4'd9,
    OP_READ        = 4'd10
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SETUP1 = 8'b0000_0100,
    ST_SETUP2 = 8'b0000_1000,
    ST_SETUP3 = 8'b0001_0000,
    ST_SCAN   = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic ready;
    logic capture;
    logic setup1;
    logic setup2;
    logic setup3;
    logic scan_start;
    logic read_issue;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clearing;
    logic pipe_busy;
    logic out_free;
    logic is_shape;
    logic is_read;
  } dp_stat_t;

endpackage

`default_nettype wire

### sv/vsr_ctrl.sv
// ----------------------------------------------------------------------------
// vsr_ctrl
// sequencer: clear pass, command capture, setup, scan or read, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module vsr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire vsr_pkg::dp_stat_t    stat,
  output vsr_pkg::ctrl_cmd_t        cmd
);

  vsr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      vsr_pkg::ST_CLEAR: begin
        if (!stat.clearing) state_next = vsr_pkg::ST_IDLE;
      end
      vsr_pkg::ST_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = vsr_pkg::ST_SETUP1;
      end
      vsr_pkg::ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        if (stat.is_shape) state_next = vsr_pkg::ST_SETUP2;
        else if (stat.is_read) state_next = vsr_pkg::ST_READ;
        else state_next = vsr_pkg::ST_DONE;
      end
      vsr_pkg::ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_next = vsr_pkg::ST_SETUP3;
      end
      vsr_pkg::ST_SETUP3: begin
        cmd.setup3     = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = vsr_pkg::ST_SCAN;
      end
      vsr_pkg::ST_SCAN: begin
        if (!stat.pipe_busy) state_next = vsr_pkg::ST_DONE;
      end
      vsr_pkg::ST_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = vsr_pkg::ST_DONE;
      end
      vsr_pkg::ST_DONE: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) state_next = vsr_pkg::ST_IDLE;
      end
      default: begin
        state_next = vsr_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/vsr_datapath.sv
// ----------------------------------------------------------------------------
// vsr_datapath
// command registers, shape setup products, voxel scan pipeline, grid memory
// ----------------------------------------------------------------------------
`default_nettype none

module vsr_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire vsr_pkg::ctrl_cmd_t                cmd,
  output vsr_pkg::dp_stat_t                      stat,
  input  wire logic [3:0]                        operation,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  x_first,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  x_second,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  y_first,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  y_second,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  z_first,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  z_second,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  radius,
  input  wire logic                              cfg_write_enable,
  input  wire logic [vsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vsr_pkg::FLD_W-1:0]         cfg_data,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic                                   voxel_on,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_red,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_green,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_blue,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_alpha
);

  localparam int CW = vsr_pkg::CRD_W;

  // paint registers
  logic [vsr_pkg::FLD_W-1:0] paint_red, paint_green, paint_blue, paint_alpha;
  logic [vsr_pkg::COL_W-1:0] paint;

  always_ff @(posedge clk) begin
    if (rst) begin
      paint_red   <= '0;
      paint_green <= '0;
      paint_blue  <= '0;
      paint_alpha <= '0;
    end else if (cfg_write_enable) begin
      unique case (vsr_pkg::reg_idx_t'(cfg_index))
        vsr_pkg::REG_RED:   paint_red   <= cfg_data;
        vsr_pkg::REG_GREEN: paint_green <= cfg_data;
        vsr_pkg::REG_BLUE:  paint_blue  <= cfg_data;
        vsr_pkg::REG_ALPHA: paint_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  assign paint = {paint_alpha, paint_blue, paint_green, paint_red};

  // captured command
  logic [3:0] op_q;
  logic signed [vsr_pkg::FLD_W-1:0] xf, xs, yf, ys, zf, zs, rad;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      xf   <= x_first;
      xs   <= x_second;
      yf   <= y_first;
      ys   <= y_second;
      zf   <= z_first;
      zs   <= z_second;
      rad  <= radius;
    end
  end

  logic signed [CW-1:0] xf_e, yf_e, zf_e, xs_e, ys_e, zs_e;
  assign xf_e = CW'(xf);
  assign yf_e = CW'(yf);
  assign zf_e = CW'(zf);
  assign xs_e = CW'(xs);
  assign ys_e = CW'(ys);
  assign zs_e = CW'(zs);

  logic is_read, is_shape;
  assign is_read  = (op_q == vsr_pkg::OP_READ);
  assign is_shape = (op_q < 4'(vsr_pkg::OP_READ));

  // setup step 1: squares, box bounds, gating
  logic cx_ok, cy_ok, cz_ok, axes_nz, r_neg;
  logic shape_ok_n;
  logic signed [15:0] xs2, ys2, zs2, rad2;

  assign cx_ok   = (xf_e >= 0) && (xf_e <= vsr_pkg::GX_S);
  assign cy_ok   = (yf_e >= 0) && (yf_e <= vsr_pkg::GY_S);
  assign cz_ok   = (zf_e >= 0) && (zf_e <= vsr_pkg::GZ_S);
  assign axes_nz = (xs != 0) && (ys != 0) && (zs != 0);
  assign r_neg   = rad[vsr_pkg::FLD_W-1];
  assign xs2     = xs * xs;
  assign ys2     = ys * ys;
  assign zs2     = zs * zs;
  assign rad2    = rad * rad;

  always_comb begin
    unique case (op_q)
      vsr_pkg::OP_SET_VOXEL, vsr_pkg::OP_CLR_VOXEL,
      vsr_pkg::OP_SET_BOX, vsr_pkg::OP_CLR_BOX:
        shape_ok_n = 1'b1;
      vsr_pkg::OP_SET_SPHERE, vsr_pkg::OP_CLR_SPHERE:
        shape_ok_n = cx_ok && cy_ok && cz_ok && !r_neg;
      vsr_pkg::OP_SET_ELLIPS, vsr_pkg::OP_CLR_ELLIPS:
        shape_ok_n = cx_ok && cy_ok && cz_ok && axes_nz;
      vsr_pkg::OP_SET_CYL, vsr_pkg::OP_SET_DISC:
        shape_ok_n = cx_ok && cz_ok && !r_neg;
      default:
        shape_ok_n = 1'b0;
    endcase
  end

  logic [vsr_pkg::AX_W-1:0] ax, ay, az;
  logic [vsr_pkg::RR_W-1:0] rr;
  logic signed [CW-1:0] lox, hix, loy, hiy, loz, hiz;
  logic shape_ok, is_set;

  always_ff @(posedge clk) begin
    if (cmd.setup1) begin
      ax       <= xs2[vsr_pkg::AX_W-1:0];
      ay       <= ys2[vsr_pkg::AX_W-1:0];
      az       <= zs2[vsr_pkg::AX_W-1:0];
      rr       <= rad2[vsr_pkg::RR_W-1:0];
      lox      <= (xf_e < xs_e) ? xf_e : xs_e;
      hix      <= (xf_e < xs_e) ? xs_e : xf_e;
      loy      <= (yf_e < ys_e) ? yf_e : ys_e;
      hiy      <= (yf_e < ys_e) ? ys_e : yf_e;
      loz      <= (zf_e < zs_e) ? zf_e : zs_e;
      hiz      <= (zf_e < zs_e) ? zs_e : zf_e;
      shape_ok <= shape_ok_n;
      is_set   <= (op_q == vsr_pkg::OP_SET_VOXEL) || (op_q == vsr_pkg::OP_SET_BOX)
               || (op_q == vsr_pkg::OP_SET_SPHERE) || (op_q == vsr_pkg::OP_SET_ELLIPS)
               || (op_q == vsr_pkg::OP_SET_CYL) || (op_q == vsr_pkg::OP_SET_DISC);
    end
  end

  // setup steps 2 and 3: ellipsoid weights
  logic [vsr_pkg::PAIR_W-1:0] ayaz, axaz, axay;
  logic [vsr_pkg::TRI_W-1:0]  axayaz;

  always_ff @(posedge clk) begin
    if (cmd.setup2) begin
      ayaz <= vsr_pkg::PAIR_W'(ay) * vsr_pkg::PAIR_W'(az);
      axaz <= vsr_pkg::PAIR_W'(ax) * vsr_pkg::PAIR_W'(az);
      axay <= vsr_pkg::PAIR_W'(ax) * vsr_pkg::PAIR_W'(ay);
    end
    if (cmd.setup3) begin
      axayaz <= vsr_pkg::TRI_W'(axay) * vsr_pkg::TRI_W'(az);
    end
  end

  // scan counter, also runs the clear pass after reset
  logic running, clr_mode;
  logic [vsr_pkg::IX_W-1:0]   ci;
  logic [vsr_pkg::IY_W-1:0]   cj;
  logic [vsr_pkg::IZ_W-1:0]   ck;
  logic [vsr_pkg::ADDR_W-1:0] caddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b1;
      clr_mode <= 1'b1;
      ci       <= '0;
      cj       <= '0;
      ck       <= '0;
      caddr    <= '0;
    end else if (cmd.scan_start) begin
      running  <= 1'b1;
      clr_mode <= 1'b0;
      ci       <= '0;
      cj       <= '0;
      ck       <= '0;
      caddr    <= '0;
    end else if (running) begin
      if (caddr == vsr_pkg::ADDR_W'(vsr_pkg::CELLS - 1)) begin
        running  <= 1'b0;
        clr_mode <= 1'b0;
      end
      caddr <= caddr + 1'b1;
      if (ck == vsr_pkg::IZ_W'(vsr_pkg::GRID_Z - 1)) begin
        ck <= '0;
        if (cj == vsr_pkg::IY_W'(vsr_pkg::GRID_Y - 1)) begin
          cj <= '0;
          ci <= ci + 1'b1;
        end else begin
          cj <= cj + 1'b1;
        end
      end else begin
        ck <= ck + 1'b1;
      end
    end
  end

  // stage a: differences, squares and plain compares
  logic signed [CW-1:0]   ie, je, ke, dx, dy, dz;
  logic signed [2*CW-1:0] dx2, dy2, dz2;

  assign ie  = CW'(ci);
  assign je  = CW'(cj);
  assign ke  = CW'(ck);
  assign dx  = ie - xf_e;
  assign dy  = je - yf_e;
  assign dz  = ke - zf_e;
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign dz2 = dz * dz;

  logic b_valid;
  logic [vsr_pkg::SQ_W-1:0]   b_sqx, b_sqy, b_sqz;
  logic b_vox, b_box, b_cylj, b_discj;
  logic [vsr_pkg::ADDR_W-1:0] b_addr;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= running && !clr_mode;
  end

  always_ff @(posedge clk) begin
    b_sqx   <= dx2[vsr_pkg::SQ_W-1:0];
    b_sqy   <= dy2[vsr_pkg::SQ_W-1:0];
    b_sqz   <= dz2[vsr_pkg::SQ_W-1:0];
    b_vox   <= (ie == xf_e) && (je == yf_e) && (ke == zf_e);
    b_box   <= (ie >= lox) && (ie < hix) && (je >= loy) && (je < hiy)
            && (ke >= loz) && (ke < hiz);
    b_cylj  <= (je < ys_e);
    b_discj <= (je == yf_e);
    b_addr  <= caddr;
  end

  // stage b: weighted squares and distance sums
  logic c_valid;
  logic [vsr_pkg::PROD_W-1:0] c_px, c_py, c_pz;
  logic [vsr_pkg::S_W-1:0]    c_s3, c_s2;
  logic c_vox, c_box, c_cylj, c_discj;
  logic [vsr_pkg::ADDR_W-1:0] c_addr;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else     c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    c_px    <= vsr_pkg::PROD_W'(b_sqx) * vsr_pkg::PROD_W'(ayaz);
    c_py    <= vsr_pkg::PROD_W'(b_sqy) * vsr_pkg::PROD_W'(axaz);
    c_pz    <= vsr_pkg::PROD_W'(b_sqz) * vsr_pkg::PROD_W'(axay);
    c_s3    <= vsr_pkg::S_W'(b_sqx) + vsr_pkg::S_W'(b_sqy) + vsr_pkg::S_W'(b_sqz);
    c_s2    <= vsr_pkg::S_W'(b_sqx) + vsr_pkg::S_W'(b_sqz);
    c_vox   <= b_vox;
    c_box   <= b_box;
    c_cylj  <= b_cylj;
    c_discj <= b_discj;
    c_addr  <= b_addr;
  end

  // stage c: inside decision
  logic [vsr_pkg::ESUM_W-1:0] esum;
  logic in_shape, hit;

  assign esum = vsr_pkg::ESUM_W'(c_px) + vsr_pkg::ESUM_W'(c_py) + vsr_pkg::ESUM_W'(c_pz);

  always_comb begin
    unique case (op_q)
      vsr_pkg::OP_SET_VOXEL, vsr_pkg::OP_CLR_VOXEL:   in_shape = c_vox;
      vsr_pkg::OP_SET_BOX, vsr_pkg::OP_CLR_BOX:       in_shape = c_box;
      vsr_pkg::OP_SET_SPHERE, vsr_pkg::OP_CLR_SPHERE: in_shape = c_s3 <= vsr_pkg::S_W'(rr);
      vsr_pkg::OP_SET_ELLIPS, vsr_pkg::OP_CLR_ELLIPS:
        in_shape = esum <= vsr_pkg::ESUM_W'(axayaz);
      vsr_pkg::OP_SET_CYL:  in_shape = c_cylj && (c_s2 <= vsr_pkg::S_W'(rr));
      vsr_pkg::OP_SET_DISC: in_shape = c_discj && (c_s2 <= vsr_pkg::S_W'(rr));
      default:              in_shape = 1'b0;
    endcase
  end

  assign hit = c_valid && shape_ok && in_shape;

  // grid memory, one write port and one registered read port
  logic                       occ_mem [vsr_pkg::CELLS];
  logic [vsr_pkg::COL_W-1:0]  col_mem [vsr_pkg::CELLS];
  logic                       occ_we, col_we, occ_wd;
  logic [vsr_pkg::COL_W-1:0]  col_wd;
  logic [vsr_pkg::ADDR_W-1:0] waddr, raddr;
  logic                       rd_ok_n, rd_ok, rd_occ;
  logic [vsr_pkg::COL_W-1:0]  rd_col;

  always_comb begin
    if (clr_mode) begin
      occ_we = running;
      col_we = running;
      occ_wd = 1'b0;
      col_wd = '0;
      waddr  = caddr;
    end else begin
      occ_we = hit;
      col_we = hit && is_set;
      occ_wd = is_set;
      col_wd = paint;
      waddr  = c_addr;
    end
  end

  assign rd_ok_n = (xf_e >= 0) && (xf_e < vsr_pkg::GX_S) && (yf_e >= 0)
                && (yf_e < vsr_pkg::GY_S) && (zf_e >= 0) && (zf_e < vsr_pkg::GZ_S);
  assign raddr = vsr_pkg::ADDR_W'((int'(xf[vsr_pkg::IX_W-1:0]) * vsr_pkg::GRID_Y
               + int'(yf[vsr_pkg::IY_W-1:0])) * vsr_pkg::GRID_Z
               + int'(zf[vsr_pkg::IZ_W-1:0]));

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[waddr] <= occ_wd;
    if (col_we) col_mem[waddr] <= col_wd;
    if (cmd.read_issue) begin
      rd_occ <= occ_mem[raddr];
      rd_col <= col_mem[raddr];
      rd_ok  <= rd_ok_n;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_read && rd_ok) begin
        voxel_on    <= rd_occ;
        voxel_red   <= rd_col[7:0];
        voxel_green <= rd_col[15:8];
        voxel_blue  <= rd_col[23:16];
        voxel_alpha <= rd_col[31:24];
      end else begin
        voxel_on    <= 1'b0;
        voxel_red   <= '0;
        voxel_green <= '0;
        voxel_blue  <= '0;
        voxel_alpha <= '0;
      end
    end
  end

  assign stat.clearing  = clr_mode;
  assign stat.pipe_busy = running || b_valid || c_valid;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.is_shape  = is_shape;
  assign stat.is_read   = is_read;

endmodule

`default_nettype wire

### sv/voxel_shape_rasterizer_core.sv
// ----------------------------------------------------------------------------
// voxel_shape_rasterizer_core
// solid shape rasterizer over a 16x16x16 voxel grid with on bit and rgba
// ----------------------------------------------------------------------------
// shape commands (0..9): capture and the setup states SETUP1..SETUP3, then a scan of
//   one voxel per cycle over all 4096 voxels, a pipeline drain through stages b and c,
//   and the hand-off, which waits while the output register is held by out_stall
// read (10): capture, SETUP1, READ, hand-off; unused codes: capture, SETUP1, hand-off
// one item at a time; a finished result waits in the output register
// after reset a clearing pass over all 4096 voxels zeroes the grid; stall stays high
`default_nettype none
`include "assert_macros.svh"

module voxel_shape_rasterizer_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [3:0]                        operation,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  x_first,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  x_second,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  y_first,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  y_second,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  z_first,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  z_second,
  input  wire logic signed [vsr_pkg::FLD_W-1:0]  radius,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   voxel_on,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_red,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_green,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_blue,
  output logic [vsr_pkg::FLD_W-1:0]              voxel_alpha,
  // paint color registers
  input  wire logic                              cfg_write_enable,
  input  wire logic [vsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vsr_pkg::FLD_W-1:0]         cfg_data
);

  vsr_pkg::ctrl_cmd_t cmd;
  vsr_pkg::dp_stat_t  stat;

  // the sequencer takes an item only when idle
  assign in_stall = !cmd.ready;

  vsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: command regs, setup products, scan pipeline, grid memory, output reg
  vsr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .x_first          (x_first),
    .x_second         (x_second),
    .y_first          (y_first),
    .y_second         (y_second),
    .z_first          (z_first),
    .z_second         (z_second),
    .radius           (radius),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .voxel_on         (voxel_on),
    .voxel_red        (voxel_red),
    .voxel_green      (voxel_green),
    .voxel_blue       (voxel_blue),
    .voxel_alpha      (voxel_alpha)
  );

  // a new scan never overlaps writes still in the pipeline
  `VSR_ASSERT(a_scan_start_idle, cmd.scan_start |-> !stat.pipe_busy, "scan started while busy")
  // a result is loaded only into a free output register
  `VSR_ASSERT(a_load_free, cmd.out_load |-> stat.out_free, "result overwrote a pending item")
  // no item is taken during the clearing pass
  `VSR_ASSERT(a_no_accept_clear, stat.clearing |-> in_stall, "item taken while clearing")
  // a load always presents a result on the next cycle
  `VSR_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not shown")

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the voxel shape rasterizer: a grid predictor tracks
// every painted or cleared voxel and checks each result item in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic       on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } voxel_result_t;

  // grid predictor plus the queue of result items still to come
  class raster_scoreboard;
    bit            occ[vsr_pkg::CELLS];
    logic [31:0]   colour[vsr_pkg::CELLS];
    logic [7:0]    paint[4];
    voxel_result_t pending[$];
    int            mismatches;

    function new();
      for (int n = 0; n < vsr_pkg::CELLS; n++) begin
        occ[n] = 0;
        colour[n] = '0;
      end
      for (int n = 0; n < 4; n++) paint[n] = '0;
      mismatches = 0;
    endfunction

    static function longint sqr(longint v);
      return v * v;
    endfunction

    static function bit centre_in(int c, int n);
      return c >= 0 && c <= n;
    endfunction

    static function bit in_span(int p, int a, int b);
      int lo;
      int hi;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      return p >= lo && p < hi;
    endfunction

    // c: x_first, x_second, y_first, y_second, z_first, z_second, radius
    function bit covers(logic [3:0] op, int i, int j, int k, int c[7]);
      longint dx, dy, dz, ax, ay, az;
      dx = i - c[0];
      dy = j - c[2];
      dz = k - c[4];
      case (op)
        vsr_pkg::OP_SET_VOXEL, vsr_pkg::OP_CLR_VOXEL:
          return i == c[0] && j == c[2] && k == c[4];
        vsr_pkg::OP_SET_BOX, vsr_pkg::OP_CLR_BOX:
          return in_span(i, c[0], c[1]) && in_span(j, c[2], c[3]) && in_span(k, c[4], c[5]);
        vsr_pkg::OP_SET_SPHERE, vsr_pkg::OP_CLR_SPHERE: begin
          if (!centre_in(c[0], vsr_pkg::GRID_X) || !centre_in(c[2], vsr_pkg::GRID_Y) ||
              !centre_in(c[4], vsr_pkg::GRID_Z) || c[6] < 0) return 0;
          return sqr(dx) + sqr(dy) + sqr(dz) <= sqr(c[6]);
        end
        vsr_pkg::OP_SET_ELLIPS, vsr_pkg::OP_CLR_ELLIPS: begin
          if (!centre_in(c[0], vsr_pkg::GRID_X) || !centre_in(c[2], vsr_pkg::GRID_Y) ||
              !centre_in(c[4], vsr_pkg::GRID_Z)) return 0;
          if (c[1] == 0 || c[3] == 0 || c[5] == 0) return 0;
          ax = sqr(c[1]);
          ay = sqr(c[3]);
          az = sqr(c[5]);
          return sqr(dx) * ay * az + sqr(dy) * ax * az + sqr(dz) * ax * ay <= ax * ay * az;
        end
        vsr_pkg::OP_SET_CYL, vsr_pkg::OP_SET_DISC: begin
          if (!centre_in(c[0], vsr_pkg::GRID_X) || !centre_in(c[4], vsr_pkg::GRID_Z) ||
              c[6] < 0) return 0;
          if (op == vsr_pkg::OP_SET_CYL ? (j >= c[3]) : (j != c[2])) return 0;
          return sqr(dx) + sqr(dz) <= sqr(c[6]);
        end
        default: return 0;
      endcase
    endfunction

    function void note_item(logic [3:0] op, int c[7]);
      voxel_result_t res;
      int            cix;
      res = '{0, 0, 0, 0, 0};
      if (op == vsr_pkg::OP_READ) begin
        if (c[0] >= 0 && c[0] < vsr_pkg::GRID_X && c[2] >= 0 && c[2] < vsr_pkg::GRID_Y &&
            c[4] >= 0 && c[4] < vsr_pkg::GRID_Z) begin
          cix = (c[0] * vsr_pkg::GRID_Y + c[2]) * vsr_pkg::GRID_Z + c[4];
          res = '{occ[cix], colour[cix][7:0], colour[cix][15:8],
                  colour[cix][23:16], colour[cix][31:24]};
        end
      end else if (op < vsr_pkg::OP_READ) begin
        for (int i = 0; i < vsr_pkg::GRID_X; i++)
          for (int j = 0; j < vsr_pkg::GRID_Y; j++)
            for (int k = 0; k < vsr_pkg::GRID_Z; k++) begin
              if (!covers(op, i, j, k, c)) continue;
              cix = (i * vsr_pkg::GRID_Y + j) * vsr_pkg::GRID_Z + k;
              if (op inside {vsr_pkg::OP_CLR_VOXEL, vsr_pkg::OP_CLR_BOX,
                             vsr_pkg::OP_CLR_SPHERE, vsr_pkg::OP_CLR_ELLIPS}) begin
                occ[cix] = 0;
              end else begin
                occ[cix] = 1;
                colour[cix] = {paint[vsr_pkg::REG_ALPHA], paint[vsr_pkg::REG_BLUE],
                               paint[vsr_pkg::REG_GREEN], paint[vsr_pkg::REG_RED]};
              end
            end
      end
      pending.push_back(res);
    endfunction

    function void check_result(voxel_result_t got);
      voxel_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.on !== want.on || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [3:0] operation = '0;
  logic signed [7:0] x_first = '0, x_second = '0, y_first = '0, y_second = '0;
  logic signed [7:0] z_first = '0, z_second = '0, radius = '0;
  logic out_valid;
  logic out_stall = 1;
  logic voxel_on;
  logic [7:0] voxel_red, voxel_green, voxel_blue, voxel_alpha;
  logic cfg_write_enable = 0;
  logic [vsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  raster_scoreboard sb = new();
  bit quiet = 0;          // no idling on either side
  bit hold_off = 0;       // receiver holds off for a long stretch
  int cycles = 0;

  voxel_shape_rasterizer_core dut (.*);

  always #6 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{voxel_on, voxel_red, voxel_green, voxel_blue, voxel_alpha});
  end

  // receiver: random stall before each result item, long holds while asked
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 6);
      if (hold_off) n = 400;
      if (n > 0) begin
        out_stall = 1;
        repeat (n) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // one command item; caller stays on the falling edge
  task automatic send_item(logic [3:0] op, int c[7]);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    x_first = 8'(c[0]); x_second = 8'(c[1]); y_first = 8'(c[2]); y_second = 8'(c[3]);
    z_first = 8'(c[4]); z_second = 8'(c[5]); radius = 8'(c[6]);
    in_valid = 1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    sb.note_item(op, c);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_paint(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    logic [7:0] v[4];
    v = '{r, g, b, a};
    for (int n = 0; n < 4; n++) begin
      cfg_write_enable = 1;
      cfg_index = vsr_pkg::reg_idx_t'(n);
      cfg_data = v[n];
      sb.paint[n] = v[n];
      @(negedge clk);
    end
    cfg_write_enable = 0;
  endtask

  // wait until every result item is in, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cmd(logic [3:0] op, int a, int b, int c, int d, int e, int f, int r);
    int v[7];
    v = '{a, b, c, d, e, f, r};
    send_item(op, v);
  endtask

  // mostly well-formed shapes near the grid, some full-range noise
  task automatic random_item();
    int v[7];
    logic [3:0] op;
    if ($urandom_range(0, 9) == 0) begin
      op = 4'($urandom_range(0, 15));
      foreach (v[n]) v[n] = int'($signed(8'($urandom)));
    end else begin
      op = ($urandom_range(0, 9) < 4) ? vsr_pkg::OP_READ : 4'($urandom_range(0, 9));
      foreach (v[n]) v[n] = $urandom_range(0, 19) - 2;
      if (op inside {vsr_pkg::OP_SET_ELLIPS, vsr_pkg::OP_CLR_ELLIPS}) begin
        v[1] = $urandom_range(0, 14) - 7;
        v[3] = $urandom_range(0, 14) - 7;
        v[5] = $urandom_range(0, 14) - 7;
      end
      v[6] = $urandom_range(0, 10) - 1;
    end
    send_item(op, v);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst = 0;

    // directed: corners, clipping, bound order, special shapes
    write_paint(8'hff, 8'h00, 8'h80, 8'h01);
    cmd(vsr_pkg::OP_SET_VOXEL, 0, 0, 0, 0, 0, 0, 0);
    cmd(vsr_pkg::OP_SET_VOXEL, 15, 0, 15, 0, 15, 0, 0);
    cmd(vsr_pkg::OP_SET_VOXEL, -128, 0, 127, 0, 0, 0, 0);
    cmd(vsr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
    cmd(vsr_pkg::OP_READ, 15, 0, 15, 0, 15, 0, 0);
    cmd(vsr_pkg::OP_READ, 127, -1, -128, 0, 16, 0, 0);
    cmd(vsr_pkg::OP_SET_BOX, 12, 3, 9, 2, 14, 4, 0);           // reversed bounds
    cmd(vsr_pkg::OP_CLR_BOX, 5, 5, 2, 9, 2, 9, 0);             // empty box
    cmd(vsr_pkg::OP_CLR_BOX, -128, 127, 4, 5, -128, 127, 0);
    cmd(vsr_pkg::OP_READ, 4, 0, 4, 0, 4, 0, 0);
    cmd(vsr_pkg::OP_SET_SPHERE, 16, 0, 16, 0, 16, 0, 6);       // centre on the grid size
    cmd(vsr_pkg::OP_SET_SPHERE, 8, 0, 8, 0, 17, 0, 5);         // centre out of range
    cmd(vsr_pkg::OP_CLR_SPHERE, 8, 0, 8, 0, 8, 0, -1);         // negative radius
    cmd(vsr_pkg::OP_CLR_SPHERE, 7, 0, 7, 0, 7, 0, 127);
    cmd(vsr_pkg::OP_SET_ELLIPS, 8, -5, 8, 3, 8, -128, 0);      // two negative semi-axes
    cmd(vsr_pkg::OP_CLR_ELLIPS, 8, 4, 8, 0, 8, 4, 0);          // zero semi-axis
    cmd(vsr_pkg::OP_READ, 8, 0, 11, 0, 8, 0, 0);
    cmd(vsr_pkg::OP_SET_CYL, 3, 0, 0, 6, 3, 0, 2);
    cmd(vsr_pkg::OP_SET_CYL, 3, 0, 0, 0, 3, 0, 2);             // zero height
    cmd(vsr_pkg::OP_SET_DISC, 10, 0, 16, 0, 10, 0, 3);         // layer outside grid
    cmd(vsr_pkg::OP_SET_DISC, 10, 0, 15, 0, 10, 0, -128);
    cmd(vsr_pkg::OP_SET_DISC, 10, 0, 15, 0, 10, 0, 3);
    cmd(vsr_pkg::OP_READ, 10, 0, 15, 0, 12, 0, 0);
    cmd(4'd11, 1, 1, 1, 1, 1, 1, 1);
    cmd(4'd15, -1, -1, -1, -1, -1, -1, -1);
    drain();

    // pressure: receiver holds off while reads keep coming
    hold_off = 1;
    for (int n = 0; n < 6; n++) cmd(vsr_pkg::OP_READ, n, 0, 0, 0, 15 - n, 0, 0);
    hold_off = 0;
    drain();

    // random phases under different paint settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_paint(8'h00, 8'h00, 8'h00, 8'h00);
        1: write_paint(8'hff, 8'hff, 8'hff, 8'hff);
        default: write_paint(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      quiet = (phase == 2);
      repeat (28) random_item();
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
